@@ design/ist_pkg.sv @@
// Shared constants and types for the integer set table.
package ist_pkg;

    // Number of entries the table can hold.
    localparam int CAPACITY = 16;

    // Width of the stored entry count, wide enough to hold CAPACITY itself.
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // Width of one stored value.
    localparam int VALUE_W = 32;

    // Width of the reported entry count.
    localparam int ENTRY_COUNT_W = 5;

    // Request operation codes; the spare code behaves as a query.
    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Per-cell control from the table controller.
    typedef struct packed {
        logic occupied;     // Cell lies below the stored count.
        logic append_here;  // Cell is the free slot that takes an appended value.
        logic remove_go;    // A remove transfer is being taken this cycle.
    } ist_cell_ctrl_t;

endpackage

@@ design/ist_cell.sv @@
// One cell of the table: holds an entry, compares it and shifts it on removal.
module ist_cell (
    input  logic                                 clk,
    input  ist_pkg::ist_cell_ctrl_t              ctrl,
    input  logic signed [ist_pkg::VALUE_W-1:0]   probe,
    input  logic signed [ist_pkg::VALUE_W-1:0]   upper_entry,
    input  logic                                 hit_below,
    output logic                                 hit_upto,
    output logic signed [ist_pkg::VALUE_W-1:0]   entry
);
    import ist_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic                      hit;

    // Match only against occupied cells; the chain carries any match from below.
    assign hit      = ctrl.occupied && (entry_reg == probe);
    assign hit_upto = hit_below || hit;
    assign entry    = entry_reg;

    // An append writes the probe; a remove pulls the neighbour down from the match upwards.
    always_ff @(posedge clk)
    begin
        if (ctrl.append_here)
        begin
            entry_reg <= probe;
        end
        else if (ctrl.remove_go && hit_upto)
        begin
            entry_reg <= upper_entry;
        end
    end

endmodule

@@ design/integer_set_table.sv @@
// Top level of the integer set table: cell row, entry count and result register.
// The table keeps up to 16 distinct signed 32-bit values in insertion order in a row of
// cells, each comparing its own entry with the request value in parallel. For each request
// the row is searched, updated and the result registered in the cycle the request transfer
// completes, so a new request is taken every cycle while the result register is free or
// being emptied. This rate rests on the update of the cell row, with its match chain running
// from the lowest cell upwards, in that same cycle. After reset the table is empty and ready
// at once.
module integer_set_table (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      req_valid,
    output logic                                      req_stall,
    input  logic [1:0]                                operation,
    input  logic signed [ist_pkg::VALUE_W-1:0]        value,
    output logic                                      rsp_valid,
    input  logic                                      rsp_stall,
    output logic                                      was_present,
    output logic [ist_pkg::ENTRY_COUNT_W-1:0]         entry_count,
    output logic                                      status
);
    import ist_pkg::*;

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      rsp_valid_reg;
    logic                      was_present_reg;
    logic [ENTRY_COUNT_W-1:0]  entry_count_reg;
    logic                      status_reg;

    logic                      req_take;
    logic                      present;
    logic                      full;
    logic                      do_append;
    logic                      do_remove;
    logic                      status_next;

    logic [CAPACITY:0]         hit_chain;
    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];

    // A request is taken unless a result is waiting and the consumer stalls.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_take  = req_valid && !req_stall;

    assign hit_chain[0] = 1'b0;
    assign present      = hit_chain[CAPACITY];
    assign full         = (count_reg == COUNT_W'(CAPACITY));

    // Decode the request into the table update and the result status.
    always_comb
    begin
        do_append   = 1'b0;
        do_remove   = 1'b0;
        status_next = STATUS_OK;
        count_next  = count_reg;
        unique case (operation)
            OP_ADD:
            begin
                if (!present)
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        do_append  = req_take;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            OP_REMOVE:
            begin
                do_remove = req_take;
                if (present)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Row of cells; the top cell refills from itself on removal.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ist_cell_ctrl_t            ctrl;
        logic signed [VALUE_W-1:0] upper;

        assign ctrl.occupied    = (COUNT_W'(i) < count_reg);
        assign ctrl.append_here = do_append && (COUNT_W'(i) == count_reg);
        assign ctrl.remove_go   = do_remove;

        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = cell_entry[i];
        end
        else
        begin : g_mid
            assign upper = cell_entry[i + 1];
        end

        ist_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .probe       (value),
            .upper_entry (upper),
            .hit_below   (hit_chain[i]),
            .hit_upto    (hit_chain[i + 1]),
            .entry       (cell_entry[i])
        );
    end

    // Entry count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each request transfer.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            was_present_reg <= present;
            entry_count_reg <= ENTRY_COUNT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign was_present = was_present_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

endmodule

@@ bench/integer_set_table_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the integer set table against a queue-based set model.
module integer_set_table_test;
    import ist_pkg::*;

    // The spare operation code has no name in the package; the block treats it as a query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 15;
    localparam int PHASE_ITEMS  = 40;

    // One expected response, field for field as the block reports it.
    typedef struct packed {
        logic                     was_present;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     status;
    } set_answer_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [1:0]               operation;
    logic signed [VALUE_W-1:0] value;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic                     was_present;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     status;

    // Model of the table contents in insertion order, and the answers still owed.
    logic [VALUE_W-1:0] set_contents[$];
    set_answer_t        pending_answers[$];
    logic [VALUE_W-1:0] value_pool[POOL_SIZE];
    int                 error_count = 0;
    bit                 back_to_back = 1'b0;
    bit                 hold_request = 1'b0;

    integer_set_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .was_present (was_present),
        .entry_count (entry_count),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    // Apply one accepted request to the set model and queue the answer it should give.
    task automatic predict_answer(input logic [1:0] op, input logic [VALUE_W-1:0] val);
        int          hit;
        int          count;
        set_answer_t ans;
        hit = -1;
        foreach (set_contents[i])
            if (hit < 0 && set_contents[i] == val)
                hit = i;
        ans.was_present = (hit >= 0);
        ans.status      = STATUS_OK;
        if (op == OP_ADD && hit < 0)
        begin
            if (set_contents.size() >= CAPACITY)
                ans.status = STATUS_FULL;
            else
                set_contents.push_back(val);
        end
        else if (op == OP_REMOVE && hit >= 0)
        begin
            // Later entries move down one place, so insertion order is kept.
            set_contents.delete(hit);
        end
        count = set_contents.size();
        ans.entry_count = count[ENTRY_COUNT_W-1:0];
        pending_answers.push_back(ans);
    endtask

    // Offer one request and wait for its transfer; valid stays high into the next request
    // when no gap follows.
    task automatic send_request(input logic [1:0] op, input logic [VALUE_W-1:0] val);
        int gap;
        gap = back_to_back ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        value     <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_answer(op, val);
    endtask

    // A value from the shared pool most of the time, so that requests often hit stored entries.
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic refill_pool();
        foreach (value_pool[i])
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: value_pool[i] = 32'h8000_0000;
                    1: value_pool[i] = 32'h7FFF_FFFF;
                    2: value_pool[i] = 32'h0000_0000;
                    default: value_pool[i] = 32'hFFFF_FFFF;
                endcase
            end
            else
                value_pool[i] = $urandom;
        end
    endtask

    function automatic logic [1:0] pick_operation(input int add_pct, input int remove_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return OP_ADD;
        else if (r < add_pct + remove_pct)
            return OP_REMOVE;
        else if ($urandom_range(0, 4) == 0)
            return OP_SPARE;
        else
            return OP_QUERY;
    endfunction

    // Requests against an empty table.
    task automatic test_empty_table();
        send_request(OP_QUERY, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h8000_0000);
    endtask

    // Extreme values, a repeated add, the spare code and a remove from the middle.
    task automatic test_extreme_values();
        send_request(OP_ADD, 32'h8000_0000);
        send_request(OP_ADD, 32'h7FFF_FFFF);
        send_request(OP_ADD, 32'h0000_0000);
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_SPARE, 32'hFFFF_FFFF);
        send_request(OP_SPARE, 32'h0000_0001);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
    endtask

    // Fill the table, then add both a new and a stored value, free a slot and use it.
    task automatic test_full_table();
        int k;
        k = 0;
        while (set_contents.size() < CAPACITY)
        begin
            send_request(OP_ADD, (k[0] ? 32'hAAAA_AA00 : 32'h5555_5500) + k);
            k++;
        end
        send_request(OP_ADD, 32'h1234_5678);
        send_request(OP_ADD, 32'h8000_0000);
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_ADD, 32'h1234_5678);
    endtask

    // The receiver holds off for a long stretch while requests keep coming back to back.
    task automatic test_backpressure();
        refill_pool();
        hold_request = 1'b1;
        back_to_back = 1'b1;
        repeat (24)
            send_request(pick_operation(40, 30), pick_value());
        back_to_back = 1'b0;
    endtask

    // Phases that alternate between filling and draining the table with pooled values.
    task automatic test_random_sequences();
        int add_pct;
        int remove_pct;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            refill_pool();
            add_pct    = phase[0] ? 20 : 60;
            remove_pct = phase[0] ? 50 : 15;
            repeat (PHASE_ITEMS)
                send_request(pick_operation(add_pct, remove_pct), pick_value());
        end
    endtask

    // Receiver side: alternating stretches of stall and no stall, plus the long hold-off.
    initial
    begin
        int run_left;
        bit stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                run_left  = 0;
                stall_now = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = !stall_now;
                    if (stall_now)
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                               : $urandom_range(1, 3);
                    else
                        run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 5);
                end
                rsp_stall <= stall_now;
                run_left--;
            end
        end
    end

    // Compare each response transfer with the oldest outstanding answer.
    always @(posedge clk)
    begin
        set_answer_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected response: was_present %0b entry_count %0d status %0b",
                         $time, was_present, entry_count, status);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (was_present !== want.was_present)
                begin
                    $display("%0t: was_present expected %0b, actual %0b",
                             $time, want.was_present, was_present);
                    error_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d, actual %0d",
                             $time, want.entry_count, entry_count);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0b, actual %0b",
                             $time, want.status, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("integer_set_table verification failed");
        $finish;
    end

    // Reset, run the tests in turn, drain and report.
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        operation <= OP_QUERY;
        value     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extreme_values();
        test_full_table();
        test_backpressure();
        test_random_sequences();
        req_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_answers.size() == 0)
            $display("integer_set_table verification clean");
        else
            $display("integer_set_table verification failed");
        $finish;
    end

endmodule
